### design/wes_pkg.sv
// wes_pkg: shared types and constants for the wheel encoder speed and odometry block
// depends on nothing; used by every module of the block
package wes_pkg;

  localparam int NUM_WHEELS = 2;

  localparam logic [7:0]  HOLES_RST = 8'd20;
  localparam logic [19:0] CIRC_RST  = 20'd204204;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_HOLES = 2'd0;
  localparam logic [1:0] CFG_CIRC  = 2'd1;

  // 2^8 * 10^6: one revolution per microsecond in q8.8
  localparam logic [31:0] Q8_US_PER_SEC = 32'd256000000;
  localparam logic [15:0] SAT16         = 16'hFFFF;
  localparam logic [9:0]  UM_TO_MM_S    = 10'd1000;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [19:0] circ_um;
    logic [7:0]  holes;
  } cfg_t;

  // pulse as classified by the front, waiting for the back
  typedef struct packed {
    logic        wheel;
    logic [31:0] step_total;
    logic        rev_done;
    logic [31:0] period;
    logic [39:0] distance;
  } work_t;

  typedef struct packed {
    logic        wheel;
    logic [31:0] step_total;
    logic        rev_done;
    logic [31:0] period;
    logic [15:0] rps_q8;
    logic [15:0] speed;
    logic [39:0] distance;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic load_direct;
    logic start_div;
    logic load_div;
  } back_ctl_t;

endpackage

### design/wes_front.sv
// wes_front: accepts encoder pulses, keeps per-wheel counters and distance
// depends on wes_pkg; pushes classified pulses into wes_fifo
module wes_front (
  input  logic                clk,
  input  logic                rst_n,
  input  wes_pkg::cfg_t       cfg,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tuser,
  input  logic [31:0]         in_tdata,
  input  logic                q_full,
  output logic                q_push,
  output wes_pkg::work_t      q_item
);

  logic [31:0] step_r  [wes_pkg::NUM_WHEELS];
  logic [7:0]  pos_r   [wes_pkg::NUM_WHEELS];
  logic [31:0] last_r  [wes_pkg::NUM_WHEELS];
  logic [39:0] dist_r  [wes_pkg::NUM_WHEELS];

  logic        accept;
  logic        side;
  logic [7:0]  holes_eff;
  logic [8:0]  pos_inc;
  logic        done;
  logic [31:0] step_nxt;
  logic [7:0]  pos_nxt;
  logic [39:0] dist_nxt;
  logic [31:0] period;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign side      = in_tuser;

  always_comb begin
    holes_eff = (cfg.holes == 8'd0) ? 8'd1 : cfg.holes;
    pos_inc   = {1'b0, pos_r[side]} + 9'd1;
    done      = pos_inc >= {1'b0, holes_eff};
    pos_nxt   = done ? 8'd0 : pos_inc[7:0];
    step_nxt  = step_r[side] + 32'd1;
    period    = done ? (in_tdata - last_r[side]) : 32'd0;
    dist_nxt  = done ? (dist_r[side] + {20'd0, cfg.circ_um}) : dist_r[side];
  end

  // a pulse from a wheel without an entry is taken and dropped
  assign q_push = accept && (32'(side) < wes_pkg::NUM_WHEELS);

  always_comb begin
    q_item.wheel      = side;
    q_item.step_total = step_nxt;
    q_item.rev_done   = done;
    q_item.period     = period;
    q_item.distance   = dist_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < wes_pkg::NUM_WHEELS; w++) begin
        step_r[w] <= '0;
        pos_r[w]  <= '0;
        last_r[w] <= '0;
        dist_r[w] <= '0;
      end
    end else if (q_push) begin
      step_r[side] <= step_nxt;
      pos_r[side]  <= pos_nxt;
      dist_r[side] <= dist_nxt;
      if (done) begin
        last_r[side] <= in_tdata;
      end
    end
  end

endmodule

### design/wes_fifo.sv
// wes_fifo: short queue of classified pulses between front and back
// depends on wes_pkg
module wes_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wes_pkg::work_t push_item,
  input  logic           pop,
  output wes_pkg::work_t head,
  output logic           empty,
  output logic           full
);

  localparam int PW = $clog2(wes_pkg::QDEPTH);

  wes_pkg::work_t mem_r [wes_pkg::QDEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [PW:0]    cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(wes_pkg::QDEPTH));
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### design/wes_back.sv
// wes_back: rate and speed divisions, output register of the result channel
// depends on wes_pkg; pops from wes_fifo
module wes_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wes_pkg::cfg_t        cfg,
  input  logic                 q_empty,
  input  wes_pkg::work_t       q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wes_pkg::result_t     out_item
);

  wes_pkg::back_state_t state_r, state_nxt;
  wes_pkg::back_ctl_t   ctl;

  wes_pkg::work_t   work_r;
  wes_pkg::result_t res_r;
  logic             valid_r;
  logic [4:0]       cnt_r;

  // two quotient lanes sharing one divisor: a = rev rate, b = speed
  logic [31:0] num_a_r, num_b_r;
  logic [31:0] rem_a_r, rem_b_r;
  logic [31:0] quo_a_r, quo_b_r;

  logic        out_free;
  logic        needs_div;
  logic [32:0] sh_a, sh_b;
  logic        ge_a, ge_b;
  logic [32:0] sub_a, sub_b;
  logic [29:0] circ_x1000;
  logic [15:0] rps_sat, speed_sat;

  assign out_free  = !valid_r || out_ready;
  assign needs_div = q_head.rev_done && (q_head.period != 32'd0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wes_pkg::BK_IDLE: if (!q_empty && needs_div) state_nxt = wes_pkg::BK_DIV;
      wes_pkg::BK_DIV:  if (cnt_r == 5'd31) state_nxt = wes_pkg::BK_FIN;
      wes_pkg::BK_FIN:  if (out_free) state_nxt = wes_pkg::BK_IDLE;
      default:          state_nxt = wes_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      wes_pkg::BK_IDLE: begin
        ctl.start_div   = !q_empty && needs_div;
        ctl.load_direct = !q_empty && !needs_div && out_free;
        ctl.pop         = ctl.start_div || ctl.load_direct;
      end
      wes_pkg::BK_DIV: ;
      wes_pkg::BK_FIN:  ctl.load_div = out_free;
      default: ;
    endcase
  end

  assign q_pop = ctl.pop;

  // one restoring step per lane
  always_comb begin
    sh_a  = {rem_a_r, num_a_r[31]};
    sh_b  = {rem_b_r, num_b_r[31]};
    ge_a  = sh_a >= {1'b0, work_r.period};
    ge_b  = sh_b >= {1'b0, work_r.period};
    sub_a = ge_a ? (sh_a - {1'b0, work_r.period}) : sh_a;
    sub_b = ge_b ? (sh_b - {1'b0, work_r.period}) : sh_b;
    circ_x1000 = {10'd0, cfg.circ_um} * {20'd0, wes_pkg::UM_TO_MM_S};
    rps_sat    = (|quo_a_r[31:16]) ? wes_pkg::SAT16 : quo_a_r[15:0];
    speed_sat  = (|quo_b_r[31:16]) ? wes_pkg::SAT16 : quo_b_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.start_div) begin
      work_r  <= q_head;
      num_a_r <= wes_pkg::Q8_US_PER_SEC;
      num_b_r <= {2'b00, circ_x1000};
      rem_a_r <= '0;
      rem_b_r <= '0;
      quo_a_r <= '0;
      quo_b_r <= '0;
    end else if (state_r == wes_pkg::BK_DIV) begin
      num_a_r <= {num_a_r[30:0], 1'b0};
      num_b_r <= {num_b_r[30:0], 1'b0};
      rem_a_r <= sub_a[31:0];
      rem_b_r <= sub_b[31:0];
      quo_a_r <= {quo_a_r[30:0], ge_a};
      quo_b_r <= {quo_b_r[30:0], ge_b};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_direct) begin
      res_r.wheel      <= q_head.wheel;
      res_r.step_total <= q_head.step_total;
      res_r.rev_done   <= q_head.rev_done;
      res_r.period     <= q_head.period;
      res_r.distance   <= q_head.distance;
      // no revolution: zeros; zero period: saturate both
      res_r.rps_q8     <= q_head.rev_done ? wes_pkg::SAT16 : 16'd0;
      res_r.speed      <= q_head.rev_done ? wes_pkg::SAT16 : 16'd0;
    end else if (ctl.load_div) begin
      res_r.wheel      <= work_r.wheel;
      res_r.step_total <= work_r.step_total;
      res_r.rev_done   <= work_r.rev_done;
      res_r.period     <= work_r.period;
      res_r.distance   <= work_r.distance;
      res_r.rps_q8     <= rps_sat;
      res_r.speed      <= speed_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wes_pkg::BK_IDLE;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.start_div) begin
        cnt_r <= '0;
      end else if (state_r == wes_pkg::BK_DIV) begin
        cnt_r <= cnt_r + 5'd1;
      end
      if (ctl.load_direct || ctl.load_div) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_item  = res_r;

endmodule

### design/wheel_encoder_speed_odometer.sv
// wheel_encoder_speed_odometer: top level of the wheel tachometer and odometer
// depends on wes_pkg, wes_front, wes_fifo and wes_back
//
// Each input item is one encoder pulse (wheel in tuser, microsecond timestamp
// in tdata) and yields exactly one result item, in order. The front updates
// the wheel's pulse count, hole position and distance in the cycle the pulse
// is accepted and hands the pulse to a two-entry queue, so pulses are taken
// one per cycle until the queue fills. A pulse that completes no revolution,
// or one with a zero period, goes straight to the output register once it is
// free. A pulse that completes a revolution runs through a 32-step restoring
// divider with two lanes (revolutions per second and surface speed share the
// period as divisor); that divider sets the sustained rate. Results are held
// in an output register, so the front keeps taking pulses while a result
// waits, until the queue fills. Configuration takes effect on the next pulse;
// the user must write it only while the block is quiet; it is not enforced.
module wheel_encoder_speed_odometer (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: index 0 holes_per_rev, index 1 circumference_um
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [19:0]  cfg_wdata,
  // pulse items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,    // [0] wheel_side
  input  logic [31:0]  in_tdata,    // [31:0] time_us
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,   // [0] wheel_out, [1] rev_done
  // [31:0] step_total, [63:32] rev_period_us, [79:64] revs_per_sec_q8,
  // [95:80] speed_mm_s, [135:96] distance_um
  output logic [135:0] out_tdata
);

  wes_pkg::cfg_t    cfg_r;
  wes_pkg::work_t   push_item, head;
  wes_pkg::result_t res;
  logic             push, pop, q_empty, q_full;

  // configuration registers, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.holes   <= wes_pkg::HOLES_RST;
      cfg_r.circ_um <= wes_pkg::CIRC_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        wes_pkg::CFG_HOLES: cfg_r.holes   <= cfg_wdata[7:0];
        wes_pkg::CFG_CIRC:  cfg_r.circ_um <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (push),
    .q_item    (push_item)
  );

  wes_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  wes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res)
  );

  // pack result fields, lowest first
  assign out_tuser = {res.rev_done, res.wheel};
  assign out_tdata = {res.distance, res.speed, res.rps_q8, res.period, res.step_total};

endmodule
